/* hw/rtl/bset_pkg.sv */
// Shared widths, command codes and controller/datapath handshake types for the bit store.
package bset_pkg;

	localparam int CMD_W   = 3;
	localparam int INDEX_W = 11;
	localparam int FIDX_W  = 10;

	typedef enum logic [CMD_W-1:0] {
		OP_GET       = 3'd0,
		OP_SET       = 3'd1,
		OP_UNSET     = 3'd2,
		OP_FIND      = 3'd3,
		OP_SET_ALL   = 3'd4,
		OP_CLEAR_ALL = 3'd5,
		OP_RESIZE    = 3'd6
	} bset_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic idle;
		logic load;
		logic div;
		logic split;
		logic rd;
		logic merge;
		logic fill_all;
		logic set_len;
		logic set_err;
		logic out_load;
	} bset_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		bset_op_t op;
		logic     idx_ge_len;
		logic     idx_gt_len;
		logic     idx_gt_max;
		logic     hit;
		logic     last_word;
		logic     out_free;
	} bset_sts_t;

endpackage

/* hw/rtl/bset_if.sv */
// Request and response channel interfaces of the bit store.
interface bset_cmd_if import bset_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [INDEX_W-1:0] index;
	logic               fill_value;

	modport source (output valid, output command, output index, output fill_value,
		input ready);
	modport sink (input valid, input command, input index, input fill_value,
		output ready);
endinterface

interface bset_rsp_if import bset_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              bit_value;
	logic              found;
	logic [FIDX_W-1:0] found_index;
	logic              status;

	modport source (output valid, output bit_value, output found, output found_index,
		output status, input ready);
	modport sink (input valid, input bit_value, input found, input found_index,
		input status, output ready);
endinterface

/* hw/rtl/bset_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module bset_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/bset_ctrl.sv */
// Controller state machine that sequences each request through the datapath.
module bset_ctrl import bset_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  bset_sts_t sts,
	output bset_ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SPLIT,
		S_READ,
		S_MERGE,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.idle = 1'b1;
				if (req_valid) begin
					ctl.load  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				ctl.div = 1'b1;
				unique case (sts.op) inside
					OP_GET, OP_SET, OP_UNSET: begin
						if (sts.idx_ge_len) begin
							ctl.set_err = 1'b1;
							state_nxt   = S_RESP;
						end else begin
							state_nxt = S_SPLIT;
						end
					end
					OP_FIND: begin
						if (sts.idx_gt_len) begin
							ctl.set_err = 1'b1;
							state_nxt   = S_RESP;
						end else if (sts.idx_ge_len) begin
							state_nxt = S_RESP;
						end else begin
							state_nxt = S_SPLIT;
						end
					end
					OP_SET_ALL, OP_CLEAR_ALL: begin
						ctl.fill_all = 1'b1;
						state_nxt    = S_RESP;
					end
					OP_RESIZE: begin
						if (sts.idx_gt_max) begin
							ctl.set_err = 1'b1;
							state_nxt   = S_RESP;
						end else if (!sts.idx_gt_len) begin
							ctl.set_len = 1'b1;
							state_nxt   = S_RESP;
						end else begin
							state_nxt = S_SPLIT;
						end
					end
					default: begin
						ctl.set_err = 1'b1;
						state_nxt   = S_RESP;
					end
				endcase
			end
			S_SPLIT: begin
				ctl.split = 1'b1;
				state_nxt = S_READ;
			end
			S_READ: begin
				ctl.rd    = 1'b1;
				state_nxt = S_MERGE;
			end
			S_MERGE: begin
				ctl.merge = 1'b1;
				state_nxt = S_RESP;
				if (sts.op == OP_FIND) begin
					if (!sts.hit && !sts.last_word) begin
						state_nxt = S_READ;
					end
				end else if (sts.op == OP_RESIZE) begin
					if (sts.last_word) begin
						ctl.set_len = 1'b1;
					end else begin
						state_nxt = S_READ;
					end
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/bset_dp.sv */
// Datapath: word store, length, index split, word scan and the response register.
module bset_dp import bset_pkg::*; #(
	parameter int MAX_BITS   = 1024,
	parameter int WORD_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bset_cmd_if.sink  cmd,
	bset_rsp_if.source rsp,
	input  bset_ctl_t ctl,
	output bset_sts_t sts
);

	localparam int NUM_WORDS = (MAX_BITS + WORD_WIDTH - 1) / WORD_WIDTH;
	localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int OFF_W     = $clog2(WORD_WIDTH);
	localparam int LEN_W     = $clog2(MAX_BITS + 1);
	localparam int X_W       = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;
	localparam int SH        = X_W;
	localparam int RECIP     = (2 ** SH) / WORD_WIDTH;
	localparam int P_W       = X_W + SH;

	// Request fields and control state.
	bset_op_t           op_q;
	logic [INDEX_W-1:0] idx_q;
	logic               fillbit_q;
	logic [LEN_W-1:0]   len_q;
	logic [NUM_WORDS-1:0] valid_q;
	logic               pattern_q;

	// Walk position.
	logic [X_W-1:0]   quo_q;
	logic [WA_W-1:0]  word_q;
	logic [OFF_W-1:0] lo_q;
	logic [X_W-1:0]   base_q;

	// Result being built and the response register.
	logic              res_bit_q;
	logic              res_found_q;
	logic [FIDX_W-1:0] res_fidx_q;
	logic              res_err_q;
	logic              rsp_valid_q;
	logic              rsp_bit_q;
	logic              rsp_found_q;
	logic [FIDX_W-1:0] rsp_fidx_q;
	logic              rsp_err_q;

	logic [X_W-1:0]        idx_x;
	logic [X_W-1:0]        len_x;
	logic [X_W-1:0]        div_in;
	logic [P_W-1:0]        prod;
	logic [X_W-1:0]        qw;
	logic [X_W-1:0]        rem0;
	logic                  corr;
	logic [X_W-1:0]        quo_fix;
	logic [X_W-1:0]        rem_fix;
	logic [X_W-1:0]        bound;
	logic [X_W-1:0]        lim;
	logic [WORD_WIDTH-1:0] ram_rd;
	logic [WORD_WIDTH-1:0] word_eff;
	logic [WORD_WIDTH-1:0] range_mask;
	logic [WORD_WIDTH-1:0] hits;
	logic [WORD_WIDTH-1:0] bit_mask;
	logic [WORD_WIDTH-1:0] wr_data;
	logic [OFF_W-1:0]      pe;
	logic [X_W-1:0]        found_pos;
	logic                  wr_en;

	assign cmd.ready = ctl.idle;

	assign idx_x  = X_W'(idx_q);
	assign len_x  = X_W'(len_q);
	assign div_in = (op_q == OP_RESIZE) ? len_x : idx_x;
	assign bound  = (op_q == OP_RESIZE) ? idx_x : len_x;

	// Word index by reciprocal multiply; the estimate is low by at most one.
	assign prod    = P_W'(div_in) * P_W'(RECIP);
	assign qw      = quo_q * X_W'(WORD_WIDTH);
	assign rem0    = div_in - qw;
	assign corr    = rem0 >= X_W'(WORD_WIDTH);
	assign quo_fix = quo_q + X_W'(corr);
	assign rem_fix = corr ? (rem0 - X_W'(WORD_WIDTH)) : rem0;

	assign lim      = bound - base_q;
	assign word_eff = valid_q[word_q] ? ram_rd : {WORD_WIDTH{pattern_q}};
	assign bit_mask = WORD_WIDTH'(1) << lo_q;

	always_comb begin
		for (int j = 0; j < WORD_WIDTH; j++) begin
			range_mask[j] = (OFF_W'(j) >= lo_q) && (X_W'(j) < lim);
		end
	end

	assign hits = word_eff & range_mask;

	always_comb begin
		pe = '0;
		for (int j = WORD_WIDTH - 1; j >= 0; j--) begin
			if (hits[j]) begin
				pe = OFF_W'(j);
			end
		end
	end

	assign found_pos = base_q + X_W'(pe);

	always_comb begin
		if (op_q == OP_RESIZE) begin
			wr_data = (word_eff & ~range_mask) | (range_mask & {WORD_WIDTH{fillbit_q}});
		end else if (op_q == OP_SET) begin
			wr_data = word_eff | bit_mask;
		end else begin
			wr_data = word_eff & ~bit_mask;
		end
	end

	assign wr_en = ctl.merge &&
		((op_q == OP_SET) || (op_q == OP_UNSET) || (op_q == OP_RESIZE));

	bset_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (NUM_WORDS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (word_q),
		.wr_data (wr_data),
		.rd_en   (ctl.rd),
		.rd_addr (word_q),
		.rd_data (ram_rd)
	);

	always_comb begin
		sts.op         = op_q;
		sts.idx_ge_len = idx_x >= len_x;
		sts.idx_gt_len = idx_x > len_x;
		sts.idx_gt_max = idx_x > X_W'(MAX_BITS);
		sts.hit        = |hits;
		sts.last_word  = ({1'b0, base_q} + (X_W+1)'(WORD_WIDTH)) >= {1'b0, bound};
		sts.out_free   = !rsp_valid_q || rsp.ready;
	end

	// Length, word valid bits and fill pattern: words never written read as the pattern.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			valid_q     <= '0;
			pattern_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.set_len) begin
				len_q <= idx_x[LEN_W-1:0];
			end
			if (ctl.fill_all) begin
				valid_q   <= '0;
				pattern_q <= (op_q == OP_SET_ALL);
			end else if (wr_en) begin
				valid_q[word_q] <= 1'b1;
			end
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q        <= bset_op_t'(cmd.command);
			idx_q       <= cmd.index;
			fillbit_q   <= cmd.fill_value;
			res_bit_q   <= 1'b0;
			res_found_q <= 1'b0;
			res_fidx_q  <= '0;
			res_err_q   <= 1'b0;
		end
		if (ctl.set_err) begin
			res_err_q <= 1'b1;
		end
		if (ctl.div) begin
			quo_q <= prod[P_W-1:SH];
		end
		if (ctl.split) begin
			word_q <= quo_fix[WA_W-1:0];
			lo_q   <= rem_fix[OFF_W-1:0];
			base_q <= div_in - rem_fix;
		end
		if (ctl.merge) begin
			word_q <= word_q + WA_W'(1);
			base_q <= base_q + X_W'(WORD_WIDTH);
			lo_q   <= '0;
			if (op_q == OP_GET) begin
				res_bit_q <= word_eff[lo_q];
			end
			if ((op_q == OP_FIND) && (|hits)) begin
				res_found_q <= 1'b1;
				res_fidx_q  <= found_pos[FIDX_W-1:0];
			end
		end
		if (ctl.out_load) begin
			rsp_bit_q   <= res_bit_q;
			rsp_found_q <= res_found_q;
			rsp_fidx_q  <= res_fidx_q;
			rsp_err_q   <= res_err_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.bit_value   = rsp_bit_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.found_index = rsp_fidx_q;
	assign rsp.status      = rsp_err_q;

endmodule

/* hw/rtl/bitset_with_next_set_search.sv */
// Top level of the bit store with find-next-set search.
//
//   channel  dir  modport  payload
//   cmd      in   sink     command[2:0], index[10:0], fill_value
//   rsp      out  source   bit_value, found, found_index[9:0], status
//
// One request is worked at a time. Get, set and unset go from one accepted
// request to the next through decode, index split, word read, merge and response.
// Find-next and a growing resize repeat the word read and merge for every further
// word visited, up to every word of the store; the read-then-merge loop comes
// from the single registered-read RAM port. Set-all, clear-all, shrinking resize
// and rejected requests go from decode straight to the response.
// Reset clears the length, the word valid bits and the fill pattern at once, so
// the store reads as all zeros without a clearing pass.
// A stalled response waits in the output register; the next request is still
// accepted and worked until its own response is ready to be loaded.
module bitset_with_next_set_search import bset_pkg::*; #(
	parameter int MAX_BITS   = 1024,
	parameter int WORD_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	bset_cmd_if.sink   cmd,
	bset_rsp_if.source rsp
);

	bset_ctl_t ctl;
	bset_sts_t sts;

	// The controller decides the sequence of steps from the datapath status.
	bset_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (cmd.valid),
		.sts       (sts),
		.ctl       (ctl)
	);

	// The datapath holds the store, the length and the response register.
	bset_dp #(
		.MAX_BITS   (MAX_BITS),
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.ctl    (ctl),
		.sts    (sts)
	);

	// Only one request is in flight, so acceptance is followed by a busy cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("request accepted while another is in flight");

	// A rejected request never reports a located bit.
	a_err_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.status && rsp.found))
		else $error("response flags both an error and a found bit");

	// A position is only reported together with found.
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.found_index == '0))
		else $error("found_index set without found");

	// A search result never carries a read bit.
	a_found_no_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found) |-> !rsp.bit_value)
		else $error("found response carries bit_value");

	// The response register is loaded only when it is free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> sts.out_free)
		else $error("response overwritten while stalled");

endmodule
